// ===== design/wdse_pkg.sv =====
// Shared package for the watchdog supervisor escalation block.
// Register indexes, event codes and reset values; no dependencies.
`timescale 1ns / 1ps

package wdse_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_TIMEOUT      = 3'd0,
    REG_PRE_WARNING  = 3'd1,
    REG_LONG_TIMEOUT = 3'd2,
    REG_RESET_PULSE  = 3'd3,
    REG_POWER_PULSE  = 3'd4,
    REG_SAMPLE_DELAY = 3'd5,
    REG_FAIL_LIMIT   = 3'd6
  } cfg_reg_t;

  // Result event codes
  typedef enum logic [1:0] {
    EV_NONE        = 2'd0,
    EV_RESET_PULSE = 2'd1,
    EV_POWER_PULSE = 2'd2
  } event_t;

  localparam int unsigned COUNT_WIDTH_DEF = 16;
  localparam int unsigned CFG_INDEX_W     = 3;
  localparam int unsigned CFG_DATA_W      = 16;
  localparam int unsigned OUT_COUNT_W     = 16;

  // Register reset values
  localparam logic [15:0] TIMEOUT_RST      = 16'(60 * 10);
  localparam logic [15:0] PRE_WARNING_RST  = 16'd0;
  localparam logic [15:0] LONG_TIMEOUT_RST = 16'(300 * 10);
  localparam logic [7:0]  RESET_PULSE_RST  = 8'd4;
  localparam logic [7:0]  POWER_PULSE_RST  = 8'd20;
  localparam logic [7:0]  SAMPLE_DELAY_RST = 8'd20;
  localparam logic [3:0]  FAIL_LIMIT_RST   = 4'd2;
  localparam logic        ENABLE_PREV_RST  = 1'b1;

endpackage

// ===== design/watchdog_supervisor_escalation_top.sv =====
// Watchdog supervisor with reset / power-cycle escalation, one tick per beat.
// An accepted beat waits in the input stage until its step loads the result.
// Throughput: one beat per cycle; the only limit is the output stall.
// The single state update stage reads and writes all counters.
// Reset (rst, synchronous, active high) resets state, config and valid flags.
// Depends on wdse_pkg.
`timescale 1ns / 1ps

module watchdog_supervisor_escalation_top #(
  parameter int unsigned COUNT_WIDTH = wdse_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // input tick channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                kick_level,
  input  logic                                enable_level,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                power_enable,
  output logic [wdse_pkg::OUT_COUNT_W-1:0]    timeout_remaining,
  output logic [wdse_pkg::OUT_COUNT_W-1:0]    pre_remaining,
  output logic                                pre_expired,
  output logic [1:0]                          event_code,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wdse_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [wdse_pkg::CFG_DATA_W-1:0]     cfg_data
);

  typedef enum logic [1:0] {
    PH_LOW  = 2'd0,
    PH_RISE = 2'd1,
    PH_HIGH = 2'd2,
    PH_FALL = 2'd3
  } phase_t;

  // Length minus one, with zero treated as one
  function automatic logic [7:0] len_m1(input logic [7:0] v);
    len_m1 = (v == 8'd0) ? 8'd0 : v - 8'd1;
  endfunction

  // Configuration registers
  logic [15:0] timeout_period;
  logic [15:0] pre_warning_time;
  logic [15:0] long_timeout_period;
  logic [7:0]  reset_pulse_ticks;
  logic [7:0]  power_pulse_ticks;
  logic [7:0]  sample_delay_ticks;
  logic [3:0]  failure_limit;

  // Supervisor state
  logic                   kick_prev, kick_prev_next;
  logic                   enable_prev, enable_prev_next;
  phase_t                 enable_phase, enable_phase_next;
  logic [7:0]             delay_count, delay_count_next;
  logic                   half_phase, half_phase_next;
  logic [COUNT_WIDTH-1:0] timeout_count, timeout_count_next;
  logic [COUNT_WIDTH-1:0] pre_count, pre_count_next;
  logic [3:0]             failure_count, failure_count_next;
  logic [7:0]             pulse_count, pulse_count_next;
  logic                   kicked_since_expiry, kicked_since_expiry_next;

  // Input register stage
  logic s1_valid;
  logic s1_kick;
  logic s1_enable;

  logic in_fire, step_fire, cfg_fire;
  logic power_next;
  wdse_pkg::event_t event_next;

  // Reload values
  logic [COUNT_WIDTH-1:0] timeout_reload, pre_reload, long_reload;
  logic [3:0]             fail_inc;
  logic [31:0]            timeout_wide, pre_wide;

  // Pre-warning write: count minus the elapsed part of the timeout
  logic [31:0]            elapsed_wide;
  logic [COUNT_WIDTH-1:0] elapsed;
  logic [31:0]            pre_cfg_diff;
  logic [COUNT_WIDTH-1:0] pre_cfg_value;

  // register writes wait until no tick is held in the input stage
  assign cfg_ready = ~s1_valid;
  assign cfg_fire  = cfg_valid & cfg_ready;
  assign in_fire   = in_valid & ~in_stall;
  assign step_fire = s1_valid & (~out_valid | ~out_stall);
  assign in_stall  = s1_valid & ~step_fire;

  assign timeout_reload = COUNT_WIDTH'(32'(timeout_period) - 32'd1);
  assign pre_reload     = (pre_warning_time == 16'd0) ? '0
                        : COUNT_WIDTH'(32'(pre_warning_time) - 32'd1);
  assign long_reload    = COUNT_WIDTH'(32'(long_timeout_period) - 32'd1);
  assign fail_inc       = failure_count + 4'd1;

  assign elapsed_wide  = 32'(timeout_period) - 32'(timeout_count);
  assign elapsed       = elapsed_wide[COUNT_WIDTH-1:0];
  assign pre_cfg_diff  = 32'(cfg_data) - 32'(elapsed);
  assign pre_cfg_value = (32'(cfg_data) > 32'(elapsed))
                       ? COUNT_WIDTH'(pre_cfg_diff) : '0;

  // One tick of the supervisor
  always_comb begin
    kick_prev_next           = kick_prev;
    enable_prev_next         = enable_prev;
    enable_phase_next        = enable_phase;
    delay_count_next         = delay_count;
    half_phase_next          = half_phase;
    timeout_count_next       = timeout_count;
    pre_count_next           = pre_count;
    failure_count_next       = failure_count;
    pulse_count_next         = pulse_count;
    kicked_since_expiry_next = kicked_since_expiry;
    power_next               = 1'b1;
    event_next               = wdse_pkg::EV_NONE;

    if (pulse_count != 8'd0) begin
      // pulse running: only the pulse counter moves
      pulse_count_next = pulse_count - 8'd1;
      power_next       = 1'b0;
    end else if (delay_count != 8'd0) begin
      // sampling delay; resample kick on its last tick
      delay_count_next = delay_count - 8'd1;
      if (delay_count == 8'd1) begin
        kick_prev_next = s1_kick;
      end
    end else begin
      // enable pin tracking, only once kicked since the last expiry
      if (kicked_since_expiry) begin
        if (s1_enable == enable_prev) begin
          enable_phase_next = s1_enable ? PH_HIGH : PH_LOW;
        end else begin
          enable_prev_next = s1_enable;
          if (s1_enable) begin
            enable_phase_next = PH_RISE;
            delay_count_next  = len_m1(sample_delay_ticks);
            kick_prev_next    = s1_kick;
          end else begin
            enable_phase_next = PH_FALL;
          end
        end
      end
      if (enable_phase_next == PH_HIGH) begin
        if (s1_kick != kick_prev) begin
          // kick edge: reload the timeout and pre-warning counts, clear failures
          kick_prev_next           = s1_kick;
          timeout_count_next       = timeout_reload;
          failure_count_next       = 4'd0;
          pre_count_next           = pre_reload;
          kicked_since_expiry_next = 1'b1;
        end else begin
          half_phase_next = ~half_phase;
          if (half_phase) begin
            if (timeout_count != '0) begin
              timeout_count_next = timeout_count - COUNT_WIDTH'(1);
              if (pre_count != '0) begin
                pre_count_next = pre_count - COUNT_WIDTH'(1);
              end
            end else begin
              // expiry: reset pulse, or power pulse at the failure limit
              timeout_count_next       = timeout_reload;
              pre_count_next           = pre_reload;
              kicked_since_expiry_next = 1'b0;
              if (fail_inc >= failure_limit) begin
                failure_count_next = 4'd0;
                pulse_count_next   = len_m1(power_pulse_ticks);
                event_next         = wdse_pkg::EV_POWER_PULSE;
              end else begin
                failure_count_next = fail_inc;
                timeout_count_next = long_reload;
                pulse_count_next   = len_m1(reset_pulse_ticks);
                event_next         = wdse_pkg::EV_RESET_PULSE;
              end
              power_next        = 1'b0;
              delay_count_next  = len_m1(sample_delay_ticks);
              enable_phase_next = PH_HIGH;
              enable_prev_next  = s1_enable;
              kick_prev_next    = s1_kick;
            end
          end
        end
      end
    end
  end

  assign timeout_wide = 32'(timeout_count_next);
  assign pre_wide     = 32'(pre_count_next);

  // Configuration and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_period      <= wdse_pkg::TIMEOUT_RST;
      pre_warning_time    <= wdse_pkg::PRE_WARNING_RST;
      long_timeout_period <= wdse_pkg::LONG_TIMEOUT_RST;
      reset_pulse_ticks   <= wdse_pkg::RESET_PULSE_RST;
      power_pulse_ticks   <= wdse_pkg::POWER_PULSE_RST;
      sample_delay_ticks  <= wdse_pkg::SAMPLE_DELAY_RST;
      failure_limit       <= wdse_pkg::FAIL_LIMIT_RST;
      kick_prev           <= 1'b0;
      enable_prev         <= wdse_pkg::ENABLE_PREV_RST;
      enable_phase        <= PH_HIGH;
      delay_count         <= len_m1(wdse_pkg::SAMPLE_DELAY_RST);
      half_phase          <= 1'b0;
      timeout_count       <= COUNT_WIDTH'(32'(wdse_pkg::TIMEOUT_RST) - 32'd1);
      pre_count           <= '0;
      failure_count       <= 4'd0;
      pulse_count         <= 8'd0;
      kicked_since_expiry <= 1'b0;
    end else if (cfg_fire) begin
      case (cfg_index)
        wdse_pkg::REG_TIMEOUT: begin
          if (cfg_data != 16'd0) begin
            timeout_period <= cfg_data;
            timeout_count  <= COUNT_WIDTH'(32'(cfg_data) - 32'd1);
          end
        end
        wdse_pkg::REG_PRE_WARNING: begin
          pre_warning_time <= cfg_data;
          pre_count        <= pre_cfg_value;
        end
        wdse_pkg::REG_LONG_TIMEOUT: long_timeout_period <= cfg_data;
        wdse_pkg::REG_RESET_PULSE:  reset_pulse_ticks   <= cfg_data[7:0];
        wdse_pkg::REG_POWER_PULSE:  power_pulse_ticks   <= cfg_data[7:0];
        wdse_pkg::REG_SAMPLE_DELAY: sample_delay_ticks  <= cfg_data[7:0];
        wdse_pkg::REG_FAIL_LIMIT:   failure_limit       <= cfg_data[3:0];
        default: ;
      endcase
    end else if (step_fire) begin
      kick_prev           <= kick_prev_next;
      enable_prev         <= enable_prev_next;
      enable_phase        <= enable_phase_next;
      delay_count         <= delay_count_next;
      half_phase          <= half_phase_next;
      timeout_count       <= timeout_count_next;
      pre_count           <= pre_count_next;
      failure_count       <= failure_count_next;
      pulse_count         <= pulse_count_next;
      kicked_since_expiry <= kicked_since_expiry_next;
    end
  end

  // Input register stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (step_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_kick   <= kick_level;
      s1_enable <= enable_level;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_fire) begin
      out_valid <= 1'b1;
    end else if (~out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      power_enable      <= power_next;
      timeout_remaining <= timeout_wide[15:0];
      pre_remaining     <= pre_wide[15:0];
      pre_expired       <= (pre_warning_time != 16'd0) && (pre_count_next == '0);
      event_code        <= event_next;
    end
  end

endmodule

// ===== design/wdse_checker.sv =====
// Port-level checker for watchdog_supervisor_escalation_top, attached by bind.
// Depends on wdse_pkg.
`timescale 1ns / 1ps

module wdse_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic                             power_enable,
  input logic [wdse_pkg::OUT_COUNT_W-1:0] timeout_remaining,
  input logic [wdse_pkg::OUT_COUNT_W-1:0] pre_remaining,
  input logic                             pre_expired,
  input logic [1:0]                       event_code
);

  // A pulse start always drops power on that beat
  a_event_power_low: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_code != wdse_pkg::EV_NONE) |-> !power_enable)
    else $error("pulse event with power enabled");

  // Pre-warning flagged only with a zero count
  a_pre_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && pre_expired |-> (pre_remaining == '0))
    else $error("pre-warning expired with nonzero count");

  // Input backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(event_code)
      && $stable(timeout_remaining) && $stable(power_enable))
    else $error("stalled result beat changed");

  // Nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind watchdog_supervisor_escalation_top wdse_checker u_wdse_checker (.*);
